FILE: hdl/aicp_pkg.sv
package aicp_pkg;

  localparam int ReqW = 3;
  localparam int ErrW = 3;
  localparam int EvkW = 3;
  localparam int NkW  = 2;

  localparam logic [ReqW-1:0] REQ_CTRL_WRITE  = 3'd0;
  localparam logic [ReqW-1:0] REQ_REMOTE_DESC = 3'd1;
  localparam logic [ReqW-1:0] REQ_SET_STATE   = 3'd2;
  localparam logic [ReqW-1:0] REQ_SET_STATUS  = 3'd3;
  localparam logic [ReqW-1:0] REQ_LOCAL_DESC  = 3'd4;
  localparam logic [ReqW-1:0] REQ_SEND_SLOT   = 3'd5;

  localparam logic [1:0] LEN_NONE    = 2'd0;
  localparam logic [1:0] LEN_OPCODE  = 2'd1;
  localparam logic [1:0] LEN_OPERAND = 2'd3;

  localparam logic [7:0] OP_SET_GAIN = 8'd1;
  localparam logic [7:0] OP_UNMUTE   = 8'd2;
  localparam logic [7:0] OP_MUTE     = 8'd3;
  localparam logic [7:0] OP_MANUAL   = 8'd4;
  localparam logic [7:0] OP_AUTO     = 8'd5;

  localparam logic [ErrW-1:0] ERR_OK         = 3'd0;
  localparam logic [ErrW-1:0] ERR_BAD_CNT    = 3'd1;
  localparam logic [ErrW-1:0] ERR_OPCODE     = 3'd2;
  localparam logic [ErrW-1:0] ERR_MUTE_DIS   = 3'd3;
  localparam logic [ErrW-1:0] ERR_RANGE      = 3'd4;
  localparam logic [ErrW-1:0] ERR_MODE       = 3'd5;
  localparam logic [ErrW-1:0] ERR_LOCAL_GAIN = 3'd6;

  localparam logic [EvkW-1:0] EV_NONE      = 3'd0;
  localparam logic [EvkW-1:0] EV_MUTE      = 3'd1;
  localparam logic [EvkW-1:0] EV_GAIN_MODE = 3'd2;
  localparam logic [EvkW-1:0] EV_GAIN      = 3'd3;
  localparam logic [EvkW-1:0] EV_DESC      = 3'd4;

  localparam logic [NkW-1:0] NK_NONE   = 2'd0;
  localparam logic [NkW-1:0] NK_STATE  = 2'd1;
  localparam logic [NkW-1:0] NK_STATUS = 2'd2;
  localparam logic [NkW-1:0] NK_DESC   = 2'd3;

  localparam logic [1:0] MUTE_OFF      = 2'd0;
  localparam logic [1:0] MUTE_ON       = 2'd1;
  localparam logic [1:0] MUTE_DISABLED = 2'd2;

  localparam logic [1:0] GM_MANUAL_ONLY = 2'd0;
  localparam logic [1:0] GM_MANUAL      = 2'd2;
  localparam logic [1:0] GM_AUTO        = 2'd3;

  localparam logic [2:0] MARK_STATE  = 3'h1;
  localparam logic [2:0] MARK_STATUS = 3'h2;
  localparam logic [2:0] MARK_DESC   = 3'h4;

  localparam logic [1:0] CFG_GAIN_MIN  = 2'd0;
  localparam logic [1:0] CFG_GAIN_MAX  = 2'd1;
  localparam logic [1:0] CFG_NOTIFY_EN = 2'd2;

  typedef struct packed {
    logic [ReqW-1:0]   req_type;
    logic [1:0]        write_len;
    logic [7:0]        opcode;
    logic [7:0]        counter_in;
    logic signed [7:0] gain_value;
    logic [1:0]        mute_in;
    logic [1:0]        gain_mode_in;
    logic              status_in;
  } item_t;

  typedef struct packed {
    logic signed [7:0] gain_min;
    logic signed [7:0] gain_max;
    logic              notify_enabled;
  } cfg_t;

  typedef struct packed {
    logic [ErrW-1:0]   error_code;
    logic [EvkW-1:0]   event_kind;
    logic [7:0]        event_value;
    logic [NkW-1:0]    notify_kind;
    logic signed [7:0] notify_gain;
    logic [1:0]        notify_mute;
    logic [1:0]        notify_gain_mode;
    logic [7:0]        notify_counter;
    logic              notify_status;
  } res_t;

endpackage

FILE: hdl/aicp_exec.sv
module aicp_exec import aicp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic signed [7:0] gain_r, gain_nxt;
  logic [1:0]        mute_r, mute_nxt;
  logic [1:0]        gmode_r, gmode_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic              status_r, status_nxt;
  logic [2:0]        marks_r, marks_nxt;

  logic       gain_ok;
  logic [2:0] mark_set;
  logic       ctrl_ok;

  assign gain_ok = (item.gain_value >= cfg.gain_min) && (item.gain_value <= cfg.gain_max);

  always_comb begin
    gain_nxt   = gain_r;
    mute_nxt   = mute_r;
    gmode_nxt  = gmode_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    marks_nxt  = marks_r;
    mark_set   = 3'b000;
    ctrl_ok    = 1'b0;
    res        = '0;

    unique case (item.req_type)
      REQ_CTRL_WRITE: begin
        if (item.write_len == LEN_NONE) begin
          res.error_code = ERR_OPCODE;
        end else if (item.write_len == LEN_OPCODE || item.counter_in != cnt_r) begin
          res.error_code = ERR_BAD_CNT;
        end else begin
          unique case (item.opcode) inside
            OP_SET_GAIN: begin
              if (item.write_len != LEN_OPERAND || !gain_ok) begin
                res.error_code = ERR_RANGE;
              end else begin
                gain_nxt = item.gain_value;
                ctrl_ok  = 1'b1;
                if (gmode_r == GM_MANUAL_ONLY || gmode_r == GM_MANUAL) begin
                  res.event_kind  = EV_GAIN;
                  res.event_value = item.gain_value;
                end
              end
            end
            OP_UNMUTE, OP_MUTE: begin
              if (mute_r == MUTE_DISABLED) begin
                res.error_code  = ERR_MUTE_DIS;
                res.event_kind  = EV_MUTE;
                res.event_value = {6'd0, MUTE_DISABLED};
              end else begin
                ctrl_ok = 1'b1;
                if (item.opcode == OP_UNMUTE && mute_r == MUTE_ON) begin
                  mute_nxt        = MUTE_OFF;
                  res.event_kind  = EV_MUTE;
                  res.event_value = {6'd0, MUTE_OFF};
                end else if (item.opcode == OP_MUTE && mute_r == MUTE_OFF) begin
                  mute_nxt        = MUTE_ON;
                  res.event_kind  = EV_MUTE;
                  res.event_value = {6'd0, MUTE_ON};
                end
              end
            end
            OP_MANUAL: begin
              if (gmode_r != GM_AUTO) begin
                res.error_code = ERR_MODE;
              end else begin
                gmode_nxt       = GM_MANUAL;
                ctrl_ok         = 1'b1;
                res.event_kind  = EV_GAIN_MODE;
                res.event_value = {6'd0, GM_MANUAL};
              end
            end
            OP_AUTO: begin
              if (gmode_r != GM_MANUAL) begin
                res.error_code = ERR_MODE;
              end else begin
                gmode_nxt       = GM_AUTO;
                ctrl_ok         = 1'b1;
                res.event_kind  = EV_GAIN_MODE;
                res.event_value = {6'd0, GM_AUTO};
              end
            end
            default: res.error_code = ERR_OPCODE;
          endcase
          if (ctrl_ok) begin
            cnt_nxt  = cnt_r + 8'd1;
            mark_set = MARK_STATE;
          end
        end
      end
      REQ_REMOTE_DESC: begin
        res.event_kind = EV_DESC;
        mark_set       = MARK_DESC;
      end
      REQ_SET_STATE: begin
        if (!gain_ok) begin
          res.error_code = ERR_LOCAL_GAIN;
        end else begin
          gain_nxt  = item.gain_value;
          mute_nxt  = item.mute_in;
          gmode_nxt = item.gain_mode_in;
          cnt_nxt   = cnt_r + 8'd1;
          mark_set  = MARK_STATE;
        end
      end
      REQ_SET_STATUS: begin
        status_nxt = item.status_in;
        mark_set   = MARK_STATUS;
      end
      REQ_LOCAL_DESC: mark_set = MARK_DESC;
      REQ_SEND_SLOT: begin
        // hand out the highest-priority mark and drop it
        if ((marks_r & MARK_STATE) != 3'b000) begin
          marks_nxt            = marks_r & ~MARK_STATE;
          res.notify_kind      = NK_STATE;
          res.notify_gain      = gain_r;
          res.notify_mute      = mute_r;
          res.notify_gain_mode = gmode_r;
          res.notify_counter   = cnt_r;
        end else if ((marks_r & MARK_STATUS) != 3'b000) begin
          marks_nxt         = marks_r & ~MARK_STATUS;
          res.notify_kind   = NK_STATUS;
          res.notify_status = status_r;
        end else if ((marks_r & MARK_DESC) != 3'b000) begin
          marks_nxt       = marks_r & ~MARK_DESC;
          res.notify_kind = NK_DESC;
        end
      end
      default: ;
    endcase

    // with no subscriber a new mark clears instead of setting
    if (mark_set != 3'b000) begin
      marks_nxt = cfg.notify_enabled ? (marks_r | mark_set) : (marks_r & ~mark_set);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= '0;
      mute_r   <= MUTE_OFF;
      gmode_r  <= GM_MANUAL_ONLY;
      cnt_r    <= '0;
      status_r <= 1'b0;
      marks_r  <= '0;
    end else if (fire) begin
      gain_r   <= gain_nxt;
      mute_r   <= mute_nxt;
      gmode_r  <= gmode_nxt;
      cnt_r    <= cnt_nxt;
      status_r <= status_nxt;
      marks_r  <= marks_nxt;
    end
  end

endmodule

FILE: hdl/audio_input_control_point_unit.sv
// Audio input control point, one instance.
// Path: a beat accepted into the input register goes through the update logic
// into the result register, where its result can be taken.
// Throughput: one beat per cycle while the result side is not stalled; the
// result register frees the input side.
// Reset (rst_n low, synchronous): state, marks and valids clear, limits
// return to -128..127 and notifications are off.
module audio_input_control_point_unit import aicp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic [1:0]        in_write_len,
  input  logic [7:0]        in_opcode,
  input  logic [7:0]        in_counter_in,
  input  logic signed [7:0] in_gain_value,
  input  logic [1:0]        in_mute_in,
  input  logic [1:0]        in_gain_mode_in,
  input  logic              in_status_in,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_error_code,
  output logic [2:0]        out_event_kind,
  output logic [7:0]        out_event_value,
  output logic [1:0]        out_notify_kind,
  output logic signed [7:0] out_notify_gain,
  output logic [1:0]        out_notify_mute,
  output logic [1:0]        out_notify_gain_mode,
  output logic [7:0]        out_notify_counter,
  output logic              out_notify_status,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  item_t item_r;
  logic  item_valid_r;
  res_t  res_r, res_nxt;
  logic  out_valid_r;
  cfg_t  cfg_r;

  logic out_free;
  logic fire;
  logic in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = item_valid_r && out_free;
  assign in_stall = item_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_min       <= -8'sd128;
      cfg_r.gain_max       <= 8'sd127;
      cfg_r.notify_enabled <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GAIN_MIN:  cfg_r.gain_min       <= cfg_data;
        CFG_GAIN_MAX:  cfg_r.gain_max       <= cfg_data;
        CFG_NOTIFY_EN: cfg_r.notify_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register: hold while the result side is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.req_type     <= in_req_type;
      item_r.write_len    <= in_write_len;
      item_r.opcode       <= in_opcode;
      item_r.counter_in   <= in_counter_in;
      item_r.gain_value   <= in_gain_value;
      item_r.mute_in      <= in_mute_in;
      item_r.gain_mode_in <= in_gain_mode_in;
      item_r.status_in    <= in_status_in;
    end
  end

  aicp_exec u_exec (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_error_code       = res_r.error_code;
  assign out_event_kind       = res_r.event_kind;
  assign out_event_value      = res_r.event_value;
  assign out_notify_kind      = res_r.notify_kind;
  assign out_notify_gain      = res_r.notify_gain;
  assign out_notify_mute      = res_r.notify_mute;
  assign out_notify_gain_mode = res_r.notify_gain_mode;
  assign out_notify_counter   = res_r.notify_counter;
  assign out_notify_status    = res_r.notify_status;

endmodule
